// File: hdl/saturating_disk_stamp_grid_assert.svh
// Assertion macros for the disk stamp grid, compiled out for synthesis
`ifndef SATURATING_DISK_STAMP_GRID_ASSERT_SVH
`define SATURATING_DISK_STAMP_GRID_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication under a synchronous active-low reset
`define SDSG_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sdsg assertion failed");

// Next-cycle implication under a synchronous active-low reset
`define SDSG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sdsg assertion failed");

`else

`define SDSG_ASSERT_NOW(label, clk, rst_n, pre, post)
`define SDSG_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// File: hdl/sdsg_pkg.sv
// Shared constants, codes and helpers for the disk stamp grid
`timescale 1ns / 1ps

package sdsg_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    // signed cell coordinate: grid span plus twice the largest radius on either side
    localparam int COORD_W     = 13;
    localparam int CELL_W      = 3;
    localparam logic [CELL_W-1:0] CELL_MAX = 3'd7;
    localparam logic [CELL_W-1:0] CELL_MIN = 3'd0;

    localparam logic [63:0] HASH_BASIS       = 64'hCBF29CE484222325;
    // prime = 2**40 + 0x1B3
    localparam logic [8:0]  HASH_PRIME_LO    = 9'h1B3;
    localparam int          HASH_PRIME_SHIFT = 40;

    localparam int PADDR_W = 3;
    localparam int DIV_W   = 13;

    typedef enum logic [1:0] {
        OP_FLASH = 2'd0,
        OP_CLEAR = 2'd1,
        OP_HASH  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_STRIPE_ENABLE = 1'b0,
        REG_STRIPE_PERIOD = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_DIVIDE,
        ST_FLASH,
        ST_HASH_READ,
        ST_HASH_MIX,
        ST_HASH_FOLD,
        ST_DONE
    } state_t;

    // advance a stripe phase by one, wrapping at the period
    function automatic logic [4:0] phase_incr(input logic [4:0] p, input logic [4:0] period);
        logic [4:0] p1;
        p1 = p + 5'd1;
        return (p1 == period) ? 5'd0 : p1;
    endfunction

endpackage

// File: hdl/saturating_disk_stamp_grid.sv
// Disk stamp grid: 3-bit saturating cell memory with flash, clear and hash sequencer
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | s_valid s_ready s_operation s_center_* | in
//          | s_radius                               |
//  result  | m_valid m_ready m_signature m_done_kind| out
//  config  | psel penable pwrite paddr pwdata       | in
//          | prdata pready                          |
//
// From accepting edge to result load: flash first finds the stripe phase remainder, then
//   walks the (4*r+1)**2 box at one cell per cycle, then finishes; clear sweeps every cell;
//   hash reads and mixes each cell in turn (the prime multiply is split in two), then folds.
// After reset a clearing pass over every cell runs with s_ready low.
// One item at a time; a new beat is taken while the last result still waits in
//   the output register, which stalls the sequencer only when it is still full.
`timescale 1ns / 1ps

`include "saturating_disk_stamp_grid_assert.svh"

module saturating_disk_stamp_grid
    import sdsg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_center_x,
    input  logic [7:0]         s_center_y,
    input  logic [4:0]         s_radius,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_signature,
    output logic [1:0]         m_done_kind,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    state_t state_reg, state_next;

    logic        stripe_enable_reg;
    logic [4:0]  stripe_period_reg;

    op_t         op_reg;
    logic [7:0]  cx_reg, cy_reg;
    logic [9:0]  r2_reg;
    logic [5:0]  lim_reg;

    logic [ADDR_W-1:0] idx_reg;

    logic [DIV_W-1:0] div_val_reg;
    logic [3:0]       div_cnt_reg;
    logic [4:0]       rem_reg;

    logic signed [6:0] dx_reg, dy_reg;
    logic [11:0]       dx2_reg, dy2_reg;
    logic [4:0]        phase_reg, row_phase_reg;

    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_up_reg;

    logic [63:0] h_reg, hx_reg, prod_reg;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    logic        m_valid_reg;
    logic [63:0] m_signature_reg;
    logic [1:0]  m_done_kind_reg;

    // control strobes
    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              sweep_we;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              idx_last;
    logic              walk_last;
    logic              cfg_we;

    // flash walk datapath
    logic signed [COORD_W-1:0] cell_x, cell_y;
    logic                      in_grid;
    logic [12:0]               d2;
    logic [11:0]               outer;
    logic                      touch, go_up;
    logic [ADDR_W-1:0]         cell_addr;
    logic [11:0]               dx2_step, dy2_step;
    logic [4:0]                row_phase_step;
    logic [6:0]                lim_s;
    logic [CELL_W-1:0]         sat_val;

    // remainder step and hash
    logic [5:0]  div_try;
    logic [4:0]  div_rem;
    logic [63:0] hx;
    logic [63:0] h_fold;

    // input beat setup
    logic [9:0]       in_r2;
    logic [DIV_W-1:0] in_div_val;
    logic [6:0]       in_lim_s;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_signature = m_signature_reg;
    assign m_done_kind = m_done_kind_reg;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_last  = (idx_reg == ADDR_W'(CELL_COUNT - 1));
    assign walk_last = (dx_reg == $signed({1'b0, lim_reg})) &&
                       (dy_reg == $signed({1'b0, lim_reg}));
    assign cfg_we    = psel && penable && pwrite && pready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stripe_enable_reg <= 1'b0;
            stripe_period_reg <= 5'd3;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_STRIPE_ENABLE: stripe_enable_reg <= pwdata[0];
                REG_STRIPE_PERIOD: stripe_period_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_STRIPE_ENABLE: prdata = {31'd0, stripe_enable_reg};
            REG_STRIPE_PERIOD: prdata = {27'd0, stripe_period_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (idx_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (op_t'(s_operation))
                        OP_FLASH: state_next = ST_DIVIDE;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_HASH:  state_next = ST_HASH_READ;
                        OP_NONE:  state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (idx_last) state_next = ST_DONE;
            end
            ST_DIVIDE: begin
                if (div_cnt_reg == 4'd0) state_next = ST_FLASH;
            end
            ST_FLASH: begin
                if (walk_last) state_next = ST_DONE;
            end
            ST_HASH_READ: state_next = ST_HASH_MIX;
            ST_HASH_MIX: begin
                state_next = idx_last ? ST_HASH_FOLD : ST_HASH_READ;
            end
            ST_HASH_FOLD: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // control outputs and memory port muxing
    always_comb begin
        sweep_we  = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        out_load  = (state_reg == ST_DONE) && out_free;
        mem_we    = sweep_we || wr_pend_reg;
        mem_waddr = sweep_we ? idx_reg : wr_addr_reg;
        mem_wdata = sweep_we ? CELL_MIN : sat_val;
        mem_raddr = (state_reg == ST_FLASH) ? cell_addr : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_INIT;
        else          state_reg <= state_next;
    end

    // flash walk: coordinates, distance and cell action
    assign lim_s  = {1'b0, lim_reg};
    assign cell_x = $signed({{(COORD_W-8){1'b0}}, cx_reg}) +
                    $signed({{(COORD_W-7){dx_reg[6]}}, dx_reg});
    assign cell_y = $signed({{(COORD_W-8){1'b0}}, cy_reg}) +
                    $signed({{(COORD_W-7){dy_reg[6]}}, dy_reg});
    assign in_grid = !cell_x[COORD_W-1] && !cell_y[COORD_W-1] &&
                     (cell_x < $signed(COORD_W'(GRID_WIDTH))) &&
                     (cell_y < $signed(COORD_W'(GRID_HEIGHT)));
    assign d2    = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign outer = {r2_reg, 2'b00};
    assign touch = in_grid && (d2 <= {1'b0, outer});
    assign go_up = (d2 <= {3'b000, r2_reg}) &&
                   (!stripe_enable_reg ||
                    ((stripe_period_reg != 5'd0) && (phase_reg < (stripe_period_reg >> 1))));
    assign cell_addr = ADDR_W'($unsigned(cell_y)) * ADDR_W'(GRID_WIDTH) +
                       ADDR_W'($unsigned(cell_x));

    // squares advance by 2*d+1
    assign dx2_step = 12'($signed({2'b00, dx2_reg}) + $signed({{6{dx_reg[6]}}, dx_reg, 1'b1}));
    assign dy2_step = 12'($signed({2'b00, dy2_reg}) + $signed({{6{dy_reg[6]}}, dy_reg, 1'b1}));
    assign row_phase_step = phase_incr(row_phase_reg, stripe_period_reg);

    assign sat_val = wr_up_reg ? ((rdata_reg == CELL_MAX) ? CELL_MAX : rdata_reg + 3'd1)
                               : ((rdata_reg == CELL_MIN) ? CELL_MIN : rdata_reg - 3'd1);

    // one restoring remainder step per cycle
    assign div_try = {rem_reg, div_val_reg[div_cnt_reg]};
    assign div_rem = (div_try >= {1'b0, stripe_period_reg})
                     ? 5'(div_try - {1'b0, stripe_period_reg}) : div_try[4:0];

    assign hx     = h_reg ^ {{(64-CELL_W){1'b0}}, rdata_reg};
    assign h_fold = prod_reg + (hx_reg << HASH_PRIME_SHIFT);

    // start phase: (cx + cy - 4r + 128*period) mod period, kept non-negative
    assign in_r2      = 10'(s_radius) * 10'(s_radius);
    assign in_lim_s   = {1'b0, s_radius, 1'b0};
    assign in_div_val = DIV_W'(s_center_x) + DIV_W'(s_center_y) +
                        DIV_W'({stripe_period_reg, 7'd0}) - DIV_W'({s_radius, 2'b00});

    // cell memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // sequencer control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_pend_reg <= (state_reg == ST_FLASH) && touch;
            if (in_accept) begin
                idx_reg <= '0;
            end else if (sweep_we || (state_reg == ST_HASH_MIX)) begin
                idx_reg <= idx_last ? '0 : idx_reg + ADDR_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        wr_addr_reg <= cell_addr;
        wr_up_reg   <= go_up;
        if (in_accept) begin
            op_reg      <= op_t'(s_operation);
            cx_reg      <= s_center_x;
            cy_reg      <= s_center_y;
            r2_reg      <= in_r2;
            lim_reg     <= {s_radius, 1'b0};
            div_val_reg <= in_div_val;
            div_cnt_reg <= 4'(DIV_W - 1);
            rem_reg     <= 5'd0;
            dx_reg      <= -$signed(in_lim_s);
            dy_reg      <= -$signed(in_lim_s);
            dx2_reg     <= {in_r2, 2'b00};
            dy2_reg     <= {in_r2, 2'b00};
            h_reg       <= HASH_BASIS;
        end
        unique case (state_reg)
            ST_DIVIDE: begin
                rem_reg     <= div_rem;
                div_cnt_reg <= div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0) begin
                    phase_reg     <= div_rem;
                    row_phase_reg <= div_rem;
                end
            end
            ST_FLASH: begin
                if (dx_reg == $signed(lim_s)) begin
                    // wrap to the next row
                    dx_reg        <= -$signed(lim_s);
                    dx2_reg       <= outer;
                    dy_reg        <= dy_reg + 7'sd1;
                    dy2_reg       <= dy2_step;
                    row_phase_reg <= row_phase_step;
                    phase_reg     <= row_phase_step;
                end else begin
                    dx_reg    <= dx_reg + 7'sd1;
                    dx2_reg   <= dx2_step;
                    phase_reg <= phase_incr(phase_reg, stripe_period_reg);
                end
            end
            ST_HASH_READ: begin
                if (idx_reg != '0) h_reg <= h_fold;
            end
            ST_HASH_MIX: begin
                hx_reg   <= hx;
                prod_reg <= hx * 64'(HASH_PRIME_LO);
            end
            ST_HASH_FOLD: h_reg <= h_fold;
            default: ;
        endcase
        if (out_load) begin
            m_signature_reg <= (op_reg == OP_HASH) ? h_reg : 64'd0;
            m_done_kind_reg <= op_reg;
        end
    end

    `SDSG_ASSERT_NOW(a_no_rmw_collision, aclk, aresetn,
        wr_pend_reg && (state_reg == ST_FLASH), wr_addr_reg != mem_raddr)
    `SDSG_ASSERT_NOW(a_walk_in_box, aclk, aresetn,
        state_reg == ST_FLASH,
        (dx_reg <= $signed(lim_s)) && (dx_reg >= -$signed(lim_s)) &&
        (dy_reg <= $signed(lim_s)) && (dy_reg >= -$signed(lim_s)))
    `SDSG_ASSERT_NOW(a_phase_below_period, aclk, aresetn,
        (state_reg == ST_FLASH) && (stripe_period_reg != 5'd0),
        phase_reg < stripe_period_reg)
    `SDSG_ASSERT_NEXT(a_idle_holds, aclk, aresetn,
        (state_reg == ST_IDLE) && !s_valid, state_reg == ST_IDLE)

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the disk stamp grid: flash, clear, signature and unused-code operations
`timescale 1ns / 1ps

module testbench;
    import sdsg_pkg::*;

    localparam logic [63:0] SIG_SEED   = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] SIG_MULT   = 64'h0000_0100_0000_01B3;
    localparam int          PHASE_LEN  = 16;

    typedef struct {
        op_t        op;
        logic [7:0] cx;
        logic [7:0] cy;
        logic [4:0] radius;
    } stamp_cmd_t;

    typedef struct {
        logic [63:0] signature;
        op_t         kind;
    } outcome_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = OP_NONE;
    logic [7:0]         s_center_x = 8'd0;
    logic [7:0]         s_center_y = 8'd0;
    logic [4:0]         s_radius = 5'd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [63:0]        m_signature;
    logic [1:0]         m_done_kind;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of the cell memory and the stripe registers
    bit [2:0]   grid_cells [CELL_COUNT];
    bit         stripe_on = 1'b0;
    int         stripe_len = 3;

    stamp_cmd_t stamp_cmds [$];
    outcome_t   expected_outcomes [$];

    bit         s_taken = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_span = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic [3:0] stall_phase = 4'd0;

    int         error_count = 0;
    int         beats_in = 0;
    int         results_seen = 0;
    int         signatures_seen = 0;
    int         flashes_seen = 0;
    int         clears_seen = 0;
    int         reg_writes = 0;

    saturating_disk_stamp_grid dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_center_x  (s_center_x),
        .s_center_y  (s_center_y),
        .s_radius    (s_radius),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_signature (m_signature),
        .m_done_kind (m_done_kind),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // stamp one disk into the shadow grid
    task automatic stamp_disk(input int cx, input int cy, input int r);
        int x, y, d2, core_lim, ring_lim, idx;
        bit raise;
        core_lim = r * r;
        ring_lim = 4 * r * r;
        for (y = cy - 2 * r; y <= cy + 2 * r; y++) begin
            for (x = cx - 2 * r; x <= cx + 2 * r; x++) begin
                d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy);
                if (x >= 0 && x < GRID_WIDTH && y >= 0 && y < GRID_HEIGHT &&
                    d2 <= ring_lim) begin
                    idx = y * GRID_WIDTH + x;
                    if (d2 > core_lim)
                        raise = 1'b0;
                    else if (!stripe_on)
                        raise = 1'b1;
                    else if (stripe_len == 0)
                        raise = 1'b0;
                    else
                        raise = ((x + y) % stripe_len) < (stripe_len / 2);
                    if (raise && grid_cells[idx] != 3'd7)
                        grid_cells[idx] = grid_cells[idx] + 3'd1;
                    else if (!raise && grid_cells[idx] != 3'd0)
                        grid_cells[idx] = grid_cells[idx] - 3'd1;
                end
            end
        end
    endtask

    function automatic logic [63:0] grid_fnv();
        logic [63:0] h;
        h = SIG_SEED;
        for (int i = 0; i < CELL_COUNT; i++)
            h = (h ^ {61'd0, grid_cells[i]}) * SIG_MULT;
        return h;
    endfunction

    // input side: bursts of beats separated by random gaps
    always @(negedge aclk) begin : drive_cmds
        stamp_cmd_t cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (stamp_cmds.size() > 0) begin
                cmd = stamp_cmds.pop_front();
                s_operation <= cmd.op;
                s_center_x <= cmd.cx;
                s_center_y <= cmd.cy;
                s_radius <= cmd.radius;
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 7);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: stall on a random mask pattern, redrawn when its span runs out
    always @(negedge aclk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(16, 200);
            stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
            stall_span--;
        end
        stall_phase = stall_phase + 4'd1;
        m_ready <= stall_mask[stall_phase];
    end

    always @(posedge aclk) begin : watch_beats
        outcome_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            // check the result before predicting the beat taken on the same edge
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got kind %0d sig %h",
                             $time, m_done_kind, m_signature);
                end else begin
                    want = expected_outcomes.pop_front();
                    results_seen++;
                    if (m_done_kind !== want.kind) begin
                        error_count++;
                        $display("%0t: done_kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, m_done_kind);
                    end
                    if (m_signature !== want.signature) begin
                        error_count++;
                        $display("%0t: signature mismatch, expected %h, got %h",
                                 $time, want.signature, m_signature);
                    end
                end
            end
            if (s_valid && s_ready) begin
                beats_in++;
                want.kind = op_t'(s_operation);
                want.signature = '0;
                case (want.kind)
                    OP_FLASH: begin
                        stamp_disk(int'(s_center_x), int'(s_center_y), int'(s_radius));
                        flashes_seen++;
                    end
                    OP_CLEAR: begin
                        foreach (grid_cells[i]) grid_cells[i] = 3'd0;
                        clears_seen++;
                    end
                    OP_HASH: begin
                        want.signature = grid_fnv();
                        signatures_seen++;
                    end
                    default: ;
                endcase
                expected_outcomes.push_back(want);
            end
        end
    end

    task automatic push_cmd(input op_t op, input int cx, input int cy, input int r);
        stamp_cmd_t cmd;
        cmd.op = op;
        cmd.cx = cx[7:0];
        cmd.cy = cy[7:0];
        cmd.radius = r[4:0];
        stamp_cmds.push_back(cmd);
    endtask

    // hold the sender until every queued beat is in and every result is out
    task automatic drain_results();
        while (stamp_cmds.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_STRIPE_ENABLE: stripe_on = value[0];
            REG_STRIPE_PERIOD: stripe_len = int'(value[4:0]);
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(248, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(0, 6);
        if (roll < 95) return $urandom_range(7, 15);
        return $urandom_range(16, 31);
    endfunction

    // mostly flashes, at most one clear and some unused codes, closed by a signature
    task automatic queue_random_phase(input int n);
        int roll, clears;
        clears = 0;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (k == n - 1) begin
                push_cmd(OP_HASH, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 31));
            end else if (roll < 5 && clears == 0) begin
                push_cmd(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 31));
                clears++;
            end else if (roll < 15) begin
                push_cmd(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 31));
            end else begin
                push_cmd(OP_FLASH, pick_coord(), pick_coord(), pick_radius());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part under the reset register values
        push_cmd(OP_HASH, 0, 0, 0);
        push_cmd(OP_FLASH, 128, 128, 31);
        push_cmd(OP_FLASH, 0, 0, 5);
        push_cmd(OP_FLASH, 255, 255, 0);
        push_cmd(OP_FLASH, 255, 0, 1);
        push_cmd(OP_FLASH, 0, 255, 31);
        push_cmd(OP_NONE, 170, 85, 21);
        push_cmd(OP_HASH, 255, 255, 31);
        // pile flashes on one spot so the core saturates at the top
        repeat (8) push_cmd(OP_FLASH, 40, 40, 2);
        push_cmd(OP_HASH, 0, 0, 0);
        push_cmd(OP_CLEAR, 0, 0, 0);
        push_cmd(OP_HASH, 0, 0, 0);
        drain_results();

        write_reg(REG_STRIPE_ENABLE, 32'd1);
        write_reg(REG_STRIPE_PERIOD, 32'd0);
        queue_random_phase(PHASE_LEN);
        drain_results();

        write_reg(REG_STRIPE_PERIOD, 32'd31);
        queue_random_phase(PHASE_LEN);
        drain_results();

        write_reg(REG_STRIPE_PERIOD, 32'd1);
        queue_random_phase(PHASE_LEN);
        drain_results();

        write_reg(REG_STRIPE_PERIOD, $urandom_range(2, 30));
        queue_random_phase(PHASE_LEN);
        drain_results();

        write_reg(REG_STRIPE_ENABLE, 32'd0);
        write_reg(REG_STRIPE_PERIOD, $urandom_range(2, 30));
        queue_random_phase(PHASE_LEN);
        drain_results();

        // watch for stray results after the last one
        repeat (1000) @(posedge aclk);

        $display("Covered %0d beats: %0d flashes, %0d clears, %0d signatures checked",
                 beats_in, flashes_seen, clears_seen, signatures_seen);
        $display("%0d results compared across %0d register writes, %0d errors",
                 results_seen, reg_writes, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #150_000_000;
        $display("Run did not finish in time, %0d results still outstanding",
                 expected_outcomes.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
